// File: rtl/max_heap_priority_queue_top_defines.svh
// Shared assertion macros for the heap queue RTL
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define HPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define HPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hpq_pkg.sv
package hpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LAST,
        ST_UP,
        ST_DOWN,
        ST_PUT,
        ST_DONE
    } state_t;

    // One response as it leaves the controller
    typedef struct packed
    {
        value_t               top_value;
        logic                 top_valid;
        logic [COUNT_W-1:0]   entry_count;
        status_t              status;
    } res_t;

endpackage

// File: rtl/hpq_req_if.sv
interface hpq_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    hpq_pkg::value_t    value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// File: rtl/hpq_rsp_if.sv
interface hpq_rsp_if;
    logic                               valid;
    logic                               ready;
    hpq_pkg::value_t                    top_value;
    logic                               top_valid;
    logic [hpq_pkg::COUNT_W-1:0]        entry_count;
    hpq_pkg::status_t                   status;

    modport source (output valid, output top_value, output top_valid,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input top_value, input top_valid,
                    input entry_count, input status, output ready);
endinterface

// File: rtl/hpq_mem.sv
module hpq_mem #(
    parameter int AW = 7
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  hpq_pkg::value_t     wr_data,
    input  logic [AW-1:0]       rd_addr_a,
    input  logic [AW-1:0]       rd_addr_b,
    output hpq_pkg::value_t     rd_data_a,
    output hpq_pkg::value_t     rd_data_b
);

    localparam int DEPTH = 1 << AW;

    hpq_pkg::value_t store_reg [DEPTH];
    hpq_pkg::value_t rd_data_a_reg;
    hpq_pkg::value_t rd_data_b_reg;

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= store_reg[rd_addr_a];
        rd_data_b_reg <= store_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// File: rtl/hpq_ctrl.sv
`include "max_heap_priority_queue_top_defines.svh"

module hpq_ctrl #(
    parameter int CAPACITY = 128,
    parameter int AW       = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    hpq_req_if.sink             req,
    output logic                res_valid,
    input  logic                res_ready,
    output hpq_pkg::res_t       res,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output hpq_pkg::value_t     wr_data,
    output logic [AW-1:0]       rd_addr_a,
    output logic [AW-1:0]       rd_addr_b,
    input  hpq_pkg::value_t     rd_data_a,
    input  hpq_pkg::value_t     rd_data_b
);

    localparam int CW = $clog2(CAPACITY + 1);

    hpq_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    hpq_pkg::value_t    val_reg, val_next;
    hpq_pkg::value_t    top_reg, top_next;
    hpq_pkg::status_t   status_reg, status_next;

    logic [CW-1:0]      new_pos;
    logic [CW-1:0]      parent_pos;
    logic [CW:0]        left_w;
    logic [CW:0]        right_w;
    logic [CW:0]        count_w;
    logic [CW-1:0]      pick_pos;
    logic [CW:0]        next_left_w;
    hpq_pkg::value_t    pick_val;
    logic [CW+7:0]      count_ext;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hpq_pkg::ST_IDLE;
            count_reg  <= '0;
            status_reg <= hpq_pkg::STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
        top_reg <= top_next;
    end

    // Heap position arithmetic
    assign new_pos     = CW'(count_reg + 1'b1);
    assign parent_pos  = pos_reg >> 1;
    assign left_w      = {pos_reg, 1'b0};
    assign right_w     = left_w + 1'b1;
    assign count_w     = {1'b0, count_reg};
    assign next_left_w = {pick_pos, 1'b0};

    // Larger child, left one on a tie
    always_comb
    begin
        if (right_w <= count_w && rd_data_a < rd_data_b)
        begin
            pick_pos = CW'(right_w);
            pick_val = rd_data_b;
        end
        else
        begin
            pick_pos = CW'(left_w);
            pick_val = rd_data_a;
        end
    end

    assign req.ready = (state_reg == hpq_pkg::ST_IDLE);

    // Sequencer: read, compare, write back the hole, move
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        top_next    = top_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = AW'(pos_reg - 1'b1);
        wr_data     = val_reg;
        rd_addr_a   = '0;
        rd_addr_b   = '0;
        res_valid   = 1'b0;

        unique case (state_reg)
            hpq_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    status_next = hpq_pkg::STATUS_DONE;
                    if (req.opcode == hpq_pkg::OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = hpq_pkg::STATUS_FULL;
                            state_next  = hpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            count_next = new_pos;
                            pos_next   = new_pos;
                            val_next   = req.value;
                            rd_addr_a  = AW'((new_pos >> 1) - 1'b1);
                            state_next = (count_reg == '0) ? hpq_pkg::ST_PUT
                                                           : hpq_pkg::ST_UP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = hpq_pkg::STATUS_EMPTY;
                            state_next  = hpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            // fetch the last entry
                            rd_addr_a  = AW'(count_reg - 1'b1);
                            count_next = CW'(count_reg - 1'b1);
                            state_next = hpq_pkg::ST_LAST;
                        end
                    end
                end
            end

            hpq_pkg::ST_LAST:
            begin
                val_next = rd_data_a;
                pos_next = CW'(1);
                if (count_reg == '0)
                begin
                    state_next = hpq_pkg::ST_DONE;
                end
                else
                begin
                    // children of the root
                    rd_addr_a  = AW'(1);
                    rd_addr_b  = AW'(2);
                    state_next = hpq_pkg::ST_DOWN;
                end
            end

            hpq_pkg::ST_UP:
            begin
                wr_en = 1'b1;
                if (val_reg > rd_data_a)
                begin
                    // parent moves down into the hole
                    wr_data  = rd_data_a;
                    pos_next = parent_pos;
                    if (parent_pos == CW'(1))
                    begin
                        state_next = hpq_pkg::ST_PUT;
                    end
                    else
                    begin
                        rd_addr_a = AW'((parent_pos >> 1) - 1'b1);
                    end
                end
                else
                begin
                    state_next = hpq_pkg::ST_DONE;
                end
            end

            hpq_pkg::ST_DOWN:
            begin
                wr_en = 1'b1;
                if (left_w > count_w || !(val_reg < pick_val))
                begin
                    if (pos_reg == CW'(1))
                    begin
                        top_next = val_reg;
                    end
                    state_next = hpq_pkg::ST_DONE;
                end
                else
                begin
                    // larger child moves up into the hole
                    wr_data = pick_val;
                    if (pos_reg == CW'(1))
                    begin
                        top_next = pick_val;
                    end
                    pos_next  = pick_pos;
                    rd_addr_a = AW'(next_left_w - 1'b1);
                    rd_addr_b = AW'(next_left_w);
                end
            end

            hpq_pkg::ST_PUT:
            begin
                wr_en      = 1'b1;
                top_next   = val_reg;
                state_next = hpq_pkg::ST_DONE;
            end

            hpq_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = hpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hpq_pkg::ST_IDLE;
            end
        endcase
    end

    // Response fields
    assign count_ext       = (CW + 8)'(count_reg);
    assign res.top_value   = (count_reg != '0) ? top_reg : '0;
    assign res.top_valid   = (count_reg != '0);
    assign res.entry_count = count_ext[7:0];
    assign res.status      = status_reg;

    `HPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `HPQ_ASSERT_NEXT(a_full_drop, state_reg == hpq_pkg::ST_IDLE && req.valid && req.opcode == hpq_pkg::OP_INSERT && count_reg == CW'(CAPACITY), state_reg == hpq_pkg::ST_DONE && status_reg == hpq_pkg::STATUS_FULL && $stable(count_reg), "insert into full heap not dropped")
    `HPQ_ASSERT_NEXT(a_remove_dec, state_reg == hpq_pkg::ST_IDLE && req.valid && req.opcode == hpq_pkg::OP_REMOVE && count_reg != '0, count_reg == CW'($past(count_reg) - 1'b1), "remove did not shrink heap")
    `HPQ_ASSERT_NOW(a_up_not_root, state_reg == hpq_pkg::ST_UP, pos_reg > CW'(1), "sift-up at root")

endmodule

// File: rtl/max_heap_priority_queue_top.sv
// Binary max-heap priority queue, one response per request.
// An ignored request (insert when full, remove when empty) goes straight to its
// response; the first insert passes PUT, an emptying remove passes LAST, and a
// sift moves one level per cycle, paced by the registered heap memory read.
// One request at a time: another is taken once the last response is handed off.
// Reset (rst_n, async, active low) empties the heap; memory is not cleared.
module max_heap_priority_queue_top #(
    parameter int CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    hpq_req_if.sink     req,
    hpq_rsp_if.source   rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic               res_valid;
    logic               res_ready;
    hpq_pkg::res_t      res;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    hpq_pkg::value_t    wr_data;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    hpq_pkg::value_t    rd_data_a;
    hpq_pkg::value_t    rd_data_b;

    logic               rsp_valid_reg;
    hpq_pkg::res_t      rsp_data_reg;

    hpq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    hpq_mem #(
        .AW (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Output register between controller and response channel
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.top_value   = rsp_data_reg.top_value;
    assign rsp.top_valid   = rsp_data_reg.top_valid;
    assign rsp.entry_count = rsp_data_reg.entry_count;
    assign rsp.status      = rsp_data_reg.status;

endmodule

// File: tb/sv/max_heap_priority_queue_top_tb.sv
`timescale 1ns / 100ps

module max_heap_priority_queue_top_tb;

    localparam int                  HEAP_DEPTH   = 128;
    localparam int                  RANDOM_REQS  = 1800;
    localparam int                  TAIL_CYCLES  = 30;
    localparam int                  CYCLE_LIMIT  = 1000000;
    localparam hpq_pkg::value_t     VAL_MIN      = hpq_pkg::value_t'(32'h8000_0000);
    localparam hpq_pkg::value_t     VAL_MAX      = hpq_pkg::value_t'(32'h7FFF_FFFF);
    localparam hpq_pkg::value_t     VAL_ONES     = hpq_pkg::value_t'(32'hFFFF_FFFF);

    // Shapes of random insert values
    typedef enum int
    {
        VS_FULL,
        VS_NARROW,
        VS_EDGE,
        VS_RISING,
        VS_FALLING
    } value_style_t;

    // Kinds of random phase
    typedef enum int
    {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_kind_t;

    // One row of the directed table
    typedef struct
    {
        hpq_pkg::op_t       op;
        hpq_pkg::value_t    val;
        bit                 typed;
        hpq_pkg::res_t      want;
    } stim_row_t;

    logic           clk;
    logic           rst_n;

    hpq_req_if      req_ch ();
    hpq_rsp_if      rsp_ch ();

    max_heap_priority_queue_top #(
        .CAPACITY   (HEAP_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch)
    );

    // Shadow copy of the heap, one-based
    hpq_pkg::value_t    shadow_heap [1:HEAP_DEPTH];
    int unsigned        shadow_len;

    hpq_pkg::res_t      pending_results [$];
    stim_row_t          directed_rows [$];
    int                 error_count;
    int                 cycle_count;
    bit                 req_quiet;
    bit                 rsp_quiet;
    hpq_pkg::value_t    ramp_value;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one request to the shadow heap and return the response it gives
    function automatic hpq_pkg::res_t heap_step_result(input hpq_pkg::op_t op,
                                                       input hpq_pkg::value_t val);
        hpq_pkg::res_t      r;
        hpq_pkg::status_t   st;
        int unsigned        pos;
        int unsigned        kid;
        hpq_pkg::value_t    tmp;
        bit                 settled;

        st = hpq_pkg::STATUS_DONE;
        if (op == hpq_pkg::OP_INSERT)
        begin
            if (shadow_len >= HEAP_DEPTH)
            begin
                st = hpq_pkg::STATUS_FULL;
            end
            else
            begin
                shadow_len++;
                shadow_heap[shadow_len] = val;
                pos = shadow_len;
                // sift up, stop at an equal parent
                while (pos > 1)
                begin
                    if (shadow_heap[pos >> 1] < shadow_heap[pos])
                    begin
                        tmp                     = shadow_heap[pos >> 1];
                        shadow_heap[pos >> 1]   = shadow_heap[pos];
                        shadow_heap[pos]        = tmp;
                        pos                     = pos >> 1;
                    end
                    else
                    begin
                        pos = 1;
                    end
                end
            end
        end
        else
        begin
            if (shadow_len == 0)
            begin
                st = hpq_pkg::STATUS_EMPTY;
            end
            else
            begin
                shadow_heap[1] = shadow_heap[shadow_len];
                shadow_len--;
                pos     = 1;
                settled = 1'b0;
                // sift down toward the larger child, left wins a tie
                while (!settled)
                begin
                    kid = 2 * pos;
                    if (kid > shadow_len)
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        if (kid + 1 <= shadow_len && shadow_heap[kid] < shadow_heap[kid + 1])
                        begin
                            kid = kid + 1;
                        end
                        if (shadow_heap[pos] < shadow_heap[kid])
                        begin
                            tmp                 = shadow_heap[pos];
                            shadow_heap[pos]    = shadow_heap[kid];
                            shadow_heap[kid]    = tmp;
                            pos                 = kid;
                        end
                        else
                        begin
                            settled = 1'b1;
                        end
                    end
                end
            end
        end

        r.top_value   = (shadow_len > 0) ? shadow_heap[1] : hpq_pkg::value_t'(0);
        r.top_valid   = (shadow_len > 0);
        r.entry_count = shadow_len[hpq_pkg::COUNT_W-1:0];
        r.status      = st;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int draw_gap(input bit quiet);
        int r;

        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic hpq_pkg::value_t draw_value(input value_style_t style);
        hpq_pkg::value_t v;

        case (style)
            VS_NARROW:
                v = hpq_pkg::value_t'($urandom_range(0, 8)) - hpq_pkg::value_t'(4);
            VS_EDGE:
            begin
                case ($urandom_range(0, 6))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MIN + 1;
                    2:       v = VAL_ONES;
                    3:       v = '0;
                    4:       v = hpq_pkg::value_t'(1);
                    5:       v = VAL_MAX - 1;
                    default: v = VAL_MAX;
                endcase
            end
            VS_RISING:
            begin
                ramp_value = ramp_value + hpq_pkg::value_t'($urandom_range(0, 1000));
                v = ramp_value;
            end
            VS_FALLING:
            begin
                ramp_value = ramp_value - hpq_pkg::value_t'($urandom_range(0, 1000));
                v = ramp_value;
            end
            default:
                v = hpq_pkg::value_t'($urandom());
        endcase
        return v;
    endfunction

    task automatic add_row(input hpq_pkg::op_t op, input hpq_pkg::value_t val,
                           input bit typed, input hpq_pkg::value_t tv,
                           input logic vld, input int cnt,
                           input hpq_pkg::status_t st);
        stim_row_t row;

        row.op                = op;
        row.val               = val;
        row.typed             = typed;
        row.want.top_value    = tv;
        row.want.top_valid    = vld;
        row.want.entry_count  = cnt[hpq_pkg::COUNT_W-1:0];
        row.want.status       = st;
        directed_rows.push_back(row);
    endtask

    // Present one request, wait for it to be taken, record its expected response
    task automatic send_request(input hpq_pkg::op_t op, input hpq_pkg::value_t val,
                                input bit typed, input hpq_pkg::res_t want);
        int             idle;
        hpq_pkg::res_t  model_res;

        idle = draw_gap(req_quiet);
        if (idle > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= val;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        model_res = heap_step_result(op, val);
        pending_results.push_back(typed ? want : model_res);
    endtask

    task automatic send_random(input hpq_pkg::op_t op, input value_style_t style);
        send_request(op, draw_value(style), 1'b0, '0);
    endtask

    // Sender holds off until every response is back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Stimulus
    initial
    begin
        int             sent;
        int             extra;
        int             n;
        phase_kind_t    kind;
        value_style_t   style;

        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.opcode <= hpq_pkg::OP_INSERT;
        req_ch.value  <= '0;
        req_quiet     = 1'b0;
        rsp_quiet     = 1'b0;
        ramp_value    = '0;
        shadow_len    = 0;
        error_count   = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty remove, extremes, equal keys, drain to empty
        add_row(hpq_pkg::OP_REMOVE, VAL_ONES, 1'b1, '0, 1'b0, 0, hpq_pkg::STATUS_EMPTY);
        add_row(hpq_pkg::OP_INSERT, VAL_MIN, 1'b1, VAL_MIN, 1'b1, 1, hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_INSERT, VAL_MAX, 1'b1, VAL_MAX, 1'b1, 2, hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_INSERT, '0, 1'b0, '0, 1'b0, 0, hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_INSERT, VAL_ONES, 1'b0, '0, 1'b0, 0, hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_INSERT, hpq_pkg::value_t'(7), 1'b0, '0, 1'b0, 0,
                hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_INSERT, hpq_pkg::value_t'(7), 1'b0, '0, 1'b0, 0,
                hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_INSERT, hpq_pkg::value_t'(7), 1'b0, '0, 1'b0, 0,
                hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_INSERT, hpq_pkg::value_t'(1), 1'b0, '0, 1'b0, 0,
                hpq_pkg::STATUS_DONE);
        for (int i = 0; i < 8; i++)
        begin
            add_row(hpq_pkg::OP_REMOVE, (i % 2) ? VAL_ONES : hpq_pkg::value_t'(0),
                    1'b0, '0, 1'b0, 0, hpq_pkg::STATUS_DONE);
        end
        add_row(hpq_pkg::OP_REMOVE, '0, 1'b1, '0, 1'b0, 0, hpq_pkg::STATUS_EMPTY);
        add_row(hpq_pkg::OP_INSERT, VAL_MIN, 1'b1, VAL_MIN, 1'b1, 1, hpq_pkg::STATUS_DONE);
        add_row(hpq_pkg::OP_REMOVE, VAL_ONES, 1'b1, '0, 1'b0, 0, hpq_pkg::STATUS_DONE);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].op, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].want);
        end
        hold_until_drained();

        // Random phases: fill to full, drain past empty, mixed churn
        sent = 0;
        while (sent < RANDOM_REQS)
        begin
            kind       = phase_kind_t'($urandom_range(0, 2));
            style      = value_style_t'($urandom_range(0, 4));
            req_quiet  = ($urandom_range(0, 3) == 0);
            rsp_quiet  = ($urandom_range(0, 3) == 0);
            ramp_value = hpq_pkg::value_t'($urandom());
            case (kind)
                PH_FILL:
                begin
                    while (shadow_len < HEAP_DEPTH)
                    begin
                        send_random(($urandom_range(0, 9) == 0) ? hpq_pkg::OP_REMOVE
                                                                : hpq_pkg::OP_INSERT,
                                    style);
                        sent++;
                    end
                    extra = $urandom_range(1, 4);
                    repeat (extra)
                    begin
                        send_random(hpq_pkg::OP_INSERT, style);
                        sent++;
                    end
                end
                PH_DRAIN:
                begin
                    while (shadow_len > 0)
                    begin
                        send_random(($urandom_range(0, 9) == 0) ? hpq_pkg::OP_INSERT
                                                                : hpq_pkg::OP_REMOVE,
                                    style);
                        sent++;
                    end
                    extra = $urandom_range(1, 3);
                    repeat (extra)
                    begin
                        send_random(hpq_pkg::OP_REMOVE, style);
                        sent++;
                    end
                end
                default:
                begin
                    n = $urandom_range(20, 80);
                    repeat (n)
                    begin
                        send_random($urandom_range(0, 1) ? hpq_pkg::OP_REMOVE
                                                         : hpq_pkg::OP_INSERT, style);
                        sent++;
                    end
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                hold_until_drained();
        end

        // Wait out every response plus some settle time
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Response side back-pressure
    initial
    begin
        int stall_left;

        rsp_ch.ready <= 1'b0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left   = draw_gap(rsp_quiet);
            end
        end
    end

    // Response checker
    always @(posedge clk)
    begin
        hpq_pkg::res_t want;

        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected response top=%0d valid=%0b count=%0d status=%0d",
                         $time, rsp_ch.top_value, rsp_ch.top_valid,
                         rsp_ch.entry_count, rsp_ch.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.top_value !== want.top_value
                    || rsp_ch.top_valid !== want.top_valid
                    || rsp_ch.entry_count !== want.entry_count
                    || rsp_ch.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: expected %0d %0b %0d %0d, actual %0d %0b %0d %0d",
                             $time, want.top_value, want.top_valid,
                             want.entry_count, want.status,
                             rsp_ch.top_value, rsp_ch.top_valid,
                             rsp_ch.entry_count, rsp_ch.status);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding",
                     $time, pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

endmodule
